FILE: rtl/core/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

  localparam int CAU_W         = 32;
  localparam int CAU_FRAC_BITS = 24;
  localparam int CAU_SW        = 2 * CAU_W + 2;
  localparam int CAU_STEPS     = CAU_W + 1;
  localparam int CAU_RW        = 2 * CAU_W + 1;
  localparam int CAU_SRW       = CAU_W + 3;

  localparam logic signed [CAU_SW-1:0] CAU_SMAX =
    {{(CAU_SW - CAU_W + 1){1'b0}}, {(CAU_W - 1){1'b1}}};
  localparam logic signed [CAU_SW-1:0] CAU_SMIN =
    {{(CAU_SW - CAU_W + 1){1'b1}}, {(CAU_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4
  } cau_cmd_e;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [CAU_W-1:0] a_re;
    logic signed [CAU_W-1:0] a_im;
    logic signed [CAU_W-1:0] b_re;
    logic signed [CAU_W-1:0] b_im;
  } cau_req_t;

  typedef struct packed {
    logic signed [CAU_W-1:0] res_re;
    logic signed [CAU_W-1:0] res_im;
    logic                    overflow;
    logic                    div_zero;
  } cau_res_t;

  typedef struct packed {
    logic [CAU_W-1:0] re;
    logic [CAU_W-1:0] im;
    logic             ov;
  } cau_fix_t;

  typedef struct packed {
    logic [2:0]                cmd;
    cau_fix_t                  fix;
    logic signed [2*CAU_W:0]   mre;
    logic signed [2*CAU_W:0]   mim;
    logic signed [2*CAU_W:0]   nre;
    logic signed [2*CAU_W:0]   nim;
    logic [2*CAU_W-1:0]        den;
    logic [2*CAU_W-1:0]        sq;
  } cau_sum_t;

  typedef struct packed {
    logic [CAU_RW-1:0] rem;
    logic [CAU_W:0]    bits;
    logic [CAU_W:0]    q;
    logic              neg;
    logic              hi;
  } cau_dlane_t;

  typedef struct packed {
    logic [CAU_SRW-1:0]  rem;
    logic [2*CAU_W+1:0]  src;
    logic [CAU_W:0]      root;
  } cau_sqrt_t;

  typedef struct packed {
    logic [2:0]         cmd;
    cau_fix_t           fix;
    cau_dlane_t         dre;
    cau_dlane_t         dim;
    logic [2*CAU_W-1:0] den;
    cau_sqrt_t          sq;
  } cau_pipe_t;

  function automatic logic [CAU_W:0] cau_sat(input logic signed [CAU_SW-1:0] v);
    logic [CAU_W:0] r;
    if (v > CAU_SMAX) begin
      r = {1'b1, CAU_SMAX[CAU_W-1:0]};
    end else if (v < CAU_SMIN) begin
      r = {1'b1, CAU_SMIN[CAU_W-1:0]};
    end else begin
      r = {1'b0, v[CAU_W-1:0]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/cau_prep.sv
`timescale 1ns / 1ps

module cau_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cau_pkg::cau_req_t req_i,
  output logic              valid_o,
  output cau_pkg::cau_sum_t sum_o
);
  import cau_pkg::*;

  logic signed [CAU_W:0]     add_re, add_im;
  logic [CAU_W:0]            sat_re, sat_im;
  cau_fix_t                  fix_d, fix_q;
  logic [2:0]                cmd_q;
  logic                      valid_q;
  logic signed [2*CAU_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [2*CAU_W-1:0] p_bb_q, p_cc_q, p_aa_q, p_dd_q;
  cau_sum_t                  sum_d, sum_q;
  logic                      valid2_q;

  always_comb begin
    add_re = '0;
    add_im = '0;
    case (req_i.cmd)
      CMD_ADD: begin
        add_re = {req_i.a_re[CAU_W-1], req_i.a_re} + {req_i.b_re[CAU_W-1], req_i.b_re};
        add_im = {req_i.a_im[CAU_W-1], req_i.a_im} + {req_i.b_im[CAU_W-1], req_i.b_im};
      end
      CMD_SUB: begin
        add_re = {req_i.a_re[CAU_W-1], req_i.a_re} - {req_i.b_re[CAU_W-1], req_i.b_re};
        add_im = {req_i.a_im[CAU_W-1], req_i.a_im} - {req_i.b_im[CAU_W-1], req_i.b_im};
      end
      default: begin
        add_re = '0;
        add_im = '0;
      end
    endcase
    sat_re = cau_sat(CAU_SW'(add_re));
    sat_im = cau_sat(CAU_SW'(add_im));
    fix_d.re = sat_re[CAU_W-1:0];
    fix_d.im = sat_im[CAU_W-1:0];
    fix_d.ov = sat_re[CAU_W] | sat_im[CAU_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid_q  <= valid_i;
      valid2_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= req_i.cmd;
    fix_q  <= fix_d;
    p_rr_q <= req_i.a_re * req_i.b_re;
    p_ii_q <= req_i.a_im * req_i.b_im;
    p_ri_q <= req_i.a_re * req_i.b_im;
    p_ir_q <= req_i.a_im * req_i.b_re;
    p_bb_q <= req_i.b_re * req_i.b_re;
    p_cc_q <= req_i.b_im * req_i.b_im;
    p_aa_q <= req_i.a_re * req_i.a_re;
    p_dd_q <= req_i.a_im * req_i.a_im;
  end

  always_comb begin
    sum_d.cmd = cmd_q;
    sum_d.fix = fix_q;
    sum_d.mre = (2*CAU_W+1)'(p_rr_q) - (2*CAU_W+1)'(p_ii_q);
    sum_d.mim = (2*CAU_W+1)'(p_ri_q) + (2*CAU_W+1)'(p_ir_q);
    sum_d.nre = (2*CAU_W+1)'(p_rr_q) + (2*CAU_W+1)'(p_ii_q);
    sum_d.nim = (2*CAU_W+1)'(p_ir_q) - (2*CAU_W+1)'(p_ri_q);
    sum_d.den = p_bb_q + p_cc_q;
    sum_d.sq  = p_aa_q + p_dd_q;
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign valid_o = valid2_q;
  assign sum_o   = sum_q;

endmodule

FILE: rtl/core/cau_init.sv
`timescale 1ns / 1ps

module cau_init #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cau_pkg::cau_sum_t  sum_i,
  output logic               valid_o,
  output cau_pkg::cau_pipe_t pipe_o
);
  import cau_pkg::*;

  localparam int DW = 3 * CAU_W + FRAC_BITS + 1;

  logic signed [2*CAU_W:0] mre_sh, mim_sh;
  logic [CAU_W:0]          sat_re, sat_im;
  cau_pipe_t               pipe_d, pipe_q;
  logic                    valid_q;

  function automatic cau_dlane_t lane_init(input logic signed [2*CAU_W:0] n,
                                           input logic [2*CAU_W-1:0] den);
    cau_dlane_t              l;
    logic signed [2*CAU_W:0] neg_n;
    logic [2*CAU_W-1:0]      mag;
    logic [DW-1:0]           dext;
    logic [DW-1:0]           dcmp;
    neg_n  = -n;
    l.neg  = n[2*CAU_W];
    mag    = l.neg ? neg_n[2*CAU_W-1:0] : n[2*CAU_W-1:0];
    dext   = DW'(mag) << FRAC_BITS;
    dcmp   = DW'(den) << (CAU_W + 1);
    l.hi   = (dext >= dcmp);
    l.rem  = CAU_RW'(dext >> (CAU_W + 1));
    l.bits = dext[CAU_W:0];
    l.q    = '0;
    return l;
  endfunction

  always_comb begin
    mre_sh = sum_i.mre >>> FRAC_BITS;
    mim_sh = sum_i.mim >>> FRAC_BITS;
    sat_re = cau_sat(CAU_SW'(mre_sh));
    sat_im = cau_sat(CAU_SW'(mim_sh));
    pipe_d.cmd = sum_i.cmd;
    case (sum_i.cmd)
      CMD_MUL: begin
        pipe_d.fix.re = sat_re[CAU_W-1:0];
        pipe_d.fix.im = sat_im[CAU_W-1:0];
        pipe_d.fix.ov = sat_re[CAU_W] | sat_im[CAU_W];
      end
      default: begin
        pipe_d.fix = sum_i.fix;
      end
    endcase
    pipe_d.dre     = lane_init(sum_i.nre, sum_i.den);
    pipe_d.dim     = lane_init(sum_i.nim, sum_i.den);
    pipe_d.den     = sum_i.den;
    pipe_d.sq.rem  = '0;
    pipe_d.sq.src  = {2'b00, sum_i.sq};
    pipe_d.sq.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

FILE: rtl/core/cau_step.sv
`timescale 1ns / 1ps

module cau_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cau_pkg::cau_pipe_t pipe_i,
  output logic               valid_o,
  output cau_pkg::cau_pipe_t pipe_o
);
  import cau_pkg::*;

  cau_pipe_t              pipe_d, pipe_q;
  logic                   valid_q;
  logic [CAU_SRW+1:0]     sx, st;
  logic                   sge;

  function automatic cau_dlane_t lane_step(input cau_dlane_t l,
                                           input logic [2*CAU_W-1:0] den);
    cau_dlane_t        r;
    logic [CAU_RW-1:0] sh;
    logic [CAU_RW-1:0] dx;
    logic              ge;
    sh     = {l.rem[CAU_RW-2:0], l.bits[CAU_W]};
    dx     = CAU_RW'(den);
    ge     = (sh >= dx);
    r      = l;
    r.rem  = ge ? sh - dx : sh;
    r.q    = {l.q[CAU_W-1:0], ge};
    r.bits = {l.bits[CAU_W-1:0], 1'b0};
    return r;
  endfunction

  always_comb begin
    pipe_d     = pipe_i;
    pipe_d.dre = lane_step(pipe_i.dre, pipe_i.den);
    pipe_d.dim = lane_step(pipe_i.dim, pipe_i.den);
    sx  = {pipe_i.sq.rem, pipe_i.sq.src[2*CAU_W+1:2*CAU_W]};
    st  = (CAU_SRW+2)'({pipe_i.sq.root, 2'b01});
    sge = (sx >= st);
    pipe_d.sq.rem  = sge ? CAU_SRW'(sx - st) : CAU_SRW'(sx);
    pipe_d.sq.root = {pipe_i.sq.root[CAU_W-1:0], sge};
    pipe_d.sq.src  = {pipe_i.sq.src[2*CAU_W-1:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

FILE: rtl/core/cau_finish.sv
`timescale 1ns / 1ps

module cau_finish (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cau_pkg::cau_pipe_t pipe_i,
  output logic               valid_o,
  output cau_pkg::cau_res_t  res_o
);
  import cau_pkg::*;

  cau_res_t       res_d, res_q;
  logic           valid_q;
  logic [CAU_W:0] lre, lim;

  function automatic logic [CAU_W:0] lane_sat(input cau_dlane_t l);
    logic [CAU_W:0] r;
    logic [CAU_W:0] nq;
    logic           big;
    nq = ~l.q + 1'b1;
    if (l.neg) begin
      big = l.hi | l.q[CAU_W] | (l.q[CAU_W-1] & (|l.q[CAU_W-2:0]));
      r   = big ? {1'b1, CAU_SMIN[CAU_W-1:0]} : {1'b0, nq[CAU_W-1:0]};
    end else begin
      big = l.hi | l.q[CAU_W] | l.q[CAU_W-1];
      r   = big ? {1'b1, CAU_SMAX[CAU_W-1:0]} : {1'b0, l.q[CAU_W-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    lre = lane_sat(pipe_i.dre);
    lim = lane_sat(pipe_i.dim);
    res_d.res_re   = pipe_i.fix.re;
    res_d.res_im   = pipe_i.fix.im;
    res_d.overflow = pipe_i.fix.ov;
    res_d.div_zero = 1'b0;
    case (pipe_i.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        res_d.res_re   = pipe_i.fix.re;
        res_d.res_im   = pipe_i.fix.im;
        res_d.overflow = pipe_i.fix.ov;
      end
      CMD_DIV: begin
        if (pipe_i.den == '0) begin
          res_d.res_re   = '0;
          res_d.res_im   = '0;
          res_d.overflow = 1'b0;
          res_d.div_zero = 1'b1;
        end else begin
          res_d.res_re   = lre[CAU_W-1:0];
          res_d.res_im   = lim[CAU_W-1:0];
          res_d.overflow = lre[CAU_W] | lim[CAU_W];
        end
      end
      CMD_MAG: begin
        res_d.res_im = '0;
        if (pipe_i.sq.root[CAU_W] | pipe_i.sq.root[CAU_W-1]) begin
          res_d.res_re   = CAU_SMAX[CAU_W-1:0];
          res_d.overflow = 1'b1;
        end else begin
          res_d.res_re   = pipe_i.sq.root[CAU_W-1:0];
          res_d.overflow = 1'b0;
        end
      end
      default: begin
        res_d.res_re   = '0;
        res_d.res_im   = '0;
        res_d.overflow = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/core/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Complex arithmetic unit: add, subtract, multiply, divide and magnitude on
// Q8.24 complex operands. A request is taken at a rising edge where start is
// high and busy is low; busy stays low, so a request may be issued every
// cycle and the sustained rate is one request per clock.
// Each request yields one result, shown on res_o for a single cycle with
// done_o high. All operations pass through the same stages, so results
// leave in request order. The pipeline depth is set by the divide and
// square root, which resolve one quotient or root bit per stage over 33
// stages, plus the product, sum, set-up and output stages.
// The receiver cannot hold results off, and nothing in the pipeline waits
// for it. Reset clears every stage valid bit, so no result appears until a
// new request arrives; there is no other state to clear.
// Sums and products saturate to the 32-bit range and set overflow; a divide
// by zero magnitude gives zero with div_zero set.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cau_pkg::cau_req_t req_i,
  output logic              busy,
  output logic              done_o,
  output cau_pkg::cau_res_t res_o
);
  import cau_pkg::*;

  logic      sum_valid;
  cau_sum_t  sum;
  logic      stg_valid [CAU_STEPS+1];
  cau_pipe_t stg_pipe  [CAU_STEPS+1];

  assign busy = 1'b0;

  cau_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .req_i   (req_i),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  cau_init #(
    .FRAC_BITS (FRAC_BITS)
  ) u_init (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .sum_i   (sum),
    .valid_o (stg_valid[0]),
    .pipe_o  (stg_pipe[0])
  );

  for (genvar g = 0; g < CAU_STEPS; g++) begin : g_step
    cau_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .pipe_i  (stg_pipe[g]),
      .valid_o (stg_valid[g+1]),
      .pipe_o  (stg_pipe[g+1])
    );
  end

  cau_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[CAU_STEPS]),
    .pipe_i  (stg_pipe[CAU_STEPS]),
    .valid_o (done_o),
    .res_o   (res_o)
  );

endmodule

FILE: sim/complex_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE_Q = 32'sh01000000;
  localparam int N_RANDOM = 950;
  localparam int N_CALM = 150;
  localparam int LATENCY = 37;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [127:0] wide_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  cau_req_t req_i = '0;
  logic     busy;
  logic     done_o;
  cau_res_t res_o;
  longint   cycles = 0;

  complex_arithmetic_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] clamp_word(input wide_t v, inout logic ov);
    if (v > wide_t'(WORD_MAX)) begin
      ov = 1'b1;
      return WORD_MAX;
    end
    if (v < wide_t'(WORD_MIN)) begin
      ov = 1'b1;
      return WORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic wide_t floor_sqrt(input wide_t s);
    wide_t r;
    wide_t t;
    r = 0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (wide_t'(1) <<< b);
      if (t * t <= s) begin
        r = t;
      end
    end
    return r;
  endfunction

  function automatic wide_t trunc_quot(input wide_t num, input wide_t den);
    wide_t q;
    q = ((num < 0 ? -num : num) <<< CAU_FRAC_BITS) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic cau_res_t complex_result(input cau_req_t r);
    cau_res_t o;
    wide_t ar, ai, br, bi, den;
    logic ov;
    ar = r.a_re;
    ai = r.a_im;
    br = r.b_re;
    bi = r.b_im;
    ov = 1'b0;
    o = '0;
    case (r.cmd)
      CMD_ADD: begin
        o.res_re = clamp_word(ar + br, ov);
        o.res_im = clamp_word(ai + bi, ov);
      end
      CMD_SUB: begin
        o.res_re = clamp_word(ar - br, ov);
        o.res_im = clamp_word(ai - bi, ov);
      end
      CMD_MUL: begin
        o.res_re = clamp_word((ar * br - ai * bi) >>> CAU_FRAC_BITS, ov);
        o.res_im = clamp_word((ar * bi + ai * br) >>> CAU_FRAC_BITS, ov);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.div_zero = 1'b1;
        end else begin
          o.res_re = clamp_word(trunc_quot(ar * br + ai * bi, den), ov);
          o.res_im = clamp_word(trunc_quot(ai * br - ar * bi, den), ov);
        end
      end
      CMD_MAG: begin
        o.res_re = clamp_word(floor_sqrt(ar * ar + ai * ai), ov);
      end
      default: ;
    endcase
    o.overflow = ov;
    return o;
  endfunction

  class cau_scoreboard;
    cau_res_t pending[$];
    int       errors = 0;

    function void note_request(cau_req_t r);
      pending.push_back(complex_result(r));
    endfunction

    function void check_result(cau_res_t got);
      cau_res_t want;
      if (pending.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.res_re !== want.res_re || got.res_im !== want.res_im ||
          got.overflow !== want.overflow || got.div_zero !== want.div_zero) begin
        report("mismatch", want, got);
      end
    endfunction

    function void report(string what, cau_res_t want, cau_res_t got);
      errors++;
      if (errors <= 10) begin
        $display("%s: expected re=%h im=%h ov=%b dz=%b, got re=%h im=%h ov=%b dz=%b",
                 what, want.res_re, want.res_im, want.overflow, want.div_zero,
                 got.res_re, got.res_im, got.overflow, got.div_zero);
      end
    endfunction
  endclass

  cau_scoreboard board = new();

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) begin
      board.note_request(req_i);
    end
    if (rst_ni && done_o) begin
      board.check_result(res_o);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("complex_arithmetic_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic issue(input cau_req_t r, input bit calm);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic issue_op(input logic [2:0] c, input logic [31:0] xr, input logic [31:0] xi,
                          input logic [31:0] yr, input logic [31:0] yi);
    cau_req_t r;
    r.cmd = c;
    r.a_re = xr;
    r.a_im = xi;
    r.b_re = yr;
    r.b_im = yi;
    issue(r, 1'b0);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 32'h03ffffff) - 32'h02000000;
      2: begin
        case ($urandom_range(0, 4))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return 32'h0;
          3: return 32'hffffffff;
          default: return ONE_Q;
        endcase
      end
      3: return ($urandom_range(0, 255) - 128) << CAU_FRAC_BITS;
      default: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
    endcase
  endfunction

  initial begin
    cau_req_t r;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    issue_op(CMD_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    issue_op(CMD_ADD, ONE_Q, -ONE_Q, ONE_Q, ONE_Q);
    issue_op(CMD_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
    issue_op(CMD_SUB, ONE_Q, 32'h1, 32'h2, 32'hffffffff);
    issue_op(CMD_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    issue_op(CMD_MUL, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX);
    issue_op(CMD_MUL, 32'hffffffff, 32'h1, 32'h1, 32'h1);
    issue_op(CMD_MUL, ONE_Q, ONE_Q, ONE_Q, -ONE_Q);
    issue_op(CMD_DIV, ONE_Q, ONE_Q, 32'h0, 32'h0);
    issue_op(CMD_DIV, WORD_MIN, WORD_MAX, 32'h0, 32'h0);
    issue_op(CMD_DIV, ONE_Q, -ONE_Q, ONE_Q, ONE_Q);
    issue_op(CMD_DIV, WORD_MAX, WORD_MIN, 32'h1, 32'h0);
    issue_op(CMD_DIV, 32'hffffffff, 32'h1, WORD_MIN, WORD_MIN);
    issue_op(CMD_DIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    issue_op(CMD_MAG, WORD_MIN, WORD_MIN, 32'h5, 32'h7);
    issue_op(CMD_MAG, WORD_MAX, 32'h0, WORD_MIN, WORD_MAX);
    issue_op(CMD_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
    issue_op(CMD_MAG, 3 * ONE_Q, -4 * ONE_Q, 32'h0, 32'h0);
    issue_op(CMD_SPARE_LO, WORD_MAX, WORD_MIN, ONE_Q, ONE_Q);
    issue_op(CMD_SPARE_LO + 3'd1, ONE_Q, ONE_Q, 32'h0, 32'h0);
    issue_op(CMD_SPARE_HI, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX);

    for (int i = 0; i < N_RANDOM; i++) begin
      r.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))
                                           : 3'($urandom_range(CMD_ADD, CMD_MAG));
      r.a_re = pick_operand();
      r.a_im = pick_operand();
      r.b_re = pick_operand();
      r.b_im = pick_operand();
      if (r.cmd == CMD_DIV && $urandom_range(0, 9) == 0) begin
        r.b_re = '0;
        r.b_im = '0;
      end
      issue(r, i >= N_RANDOM - N_CALM);
    end
    @(negedge clk_i);
    start = 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("complex_arithmetic_unit_tb: PASS");
    end else begin
      $display("complex_arithmetic_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
